// ===== rtl/arbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arbs_pkg
// Shared types, codes and reset constants of the adaptive receive-buffer
// sizer.
// ----------------------------------------------------------------------------
package arbs_pkg;

   // latency fixed point: fraction bits of a millisecond
   localparam int LATENCY_FRAC_BITS = 4;

   // item opcodes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_ADJUST = 2'd2;

   // congestion levels
   localparam logic [1:0] LEVEL_NONE   = 2'd0;
   localparam logic [1:0] LEVEL_MILD   = 2'd1;
   localparam logic [1:0] LEVEL_SEVERE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_MIN_SIZE     = 3'd0;
   localparam logic [2:0] CSR_MAX_SIZE     = 3'd1;
   localparam logic [2:0] CSR_INIT_SIZE    = 3'd2;
   localparam logic [2:0] CSR_INTERVAL     = 3'd3;
   localparam logic [2:0] CSR_SEVERE_LAT   = 3'd4;
   localparam logic [2:0] CSR_MILD_LAT     = 3'd5;
   localparam logic [2:0] CSR_LOW_LAT      = 3'd6;

   // reset values
   localparam logic [23:0] MIN_SIZE_RESET   = 24'd65536;
   localparam logic [23:0] MAX_SIZE_RESET   = 24'd2097152;
   localparam logic [23:0] INIT_SIZE_RESET  = 24'd524288;
   localparam logic [15:0] INTERVAL_RESET   = 16'd60;
   localparam logic [19:0] SEVERE_LAT_RESET = 20'(200 << LATENCY_FRAC_BITS);
   localparam logic [19:0] MILD_LAT_RESET   = 20'(100 << LATENCY_FRAC_BITS);
   localparam logic [19:0] LOW_LAT_RESET    = 20'(30 << LATENCY_FRAC_BITS);
   localparam logic [19:0] AVG_LAT_RESET    = 20'(50 << LATENCY_FRAC_BITS);

   // divide by five: floor(x * ceil(2^26 / 5) / 2^26) is exact for x < 2^26
   localparam logic [23:0] DIV5_RECIP = 24'd13421773;

   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [23:0] min_size;
      logic [23:0] max_size;
      logic [15:0] interval;
      logic [19:0] severe_lat;
      logic [19:0] mild_lat;
      logic [19:0] low_lat;
   } cfg_type;

   typedef struct packed {
      logic [23:0] size;
      logic [19:0] avg_lat;
      logic [1:0]  level;
      logic [63:0] bytes;
      logic [63:0] packets;
      logic [15:0] ticks;
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/arbs_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arbs_update
// Next-state logic for one item: totals, smoothed latency, congestion level,
// tick counter and the grow / shrink decision, with one shared divide by five.
// ----------------------------------------------------------------------------
module arbs_update (
   input  arbs_pkg::cfg_type   cfg_i,
   input  arbs_pkg::state_type state_i,
   input  logic [1:0]          opcode_i,
   input  logic [15:0]         pkt_bytes_i,
   input  logic [19:0]         latency_i,
   output arbs_pkg::state_type state_o,
   output logic                resized_o
);
   import arbs_pkg::*;

   logic [25:0] div_num;
   logic [49:0] div_prod;
   logic [23:0] div_quo;
   logic [24:0] grow_full;
   logic [23:0] grow_size;
   logic [23:0] shrink_size;
   logic [23:0] next_size;
   logic        eligible;

   // shared divide by five: (4*avg + latency) for samples, 4*size otherwise
   always_comb begin
      if (opcode_i == OP_SAMPLE) begin
         div_num = 26'({state_i.avg_lat, 2'b00}) + 26'(latency_i);
      end else begin
         div_num = {state_i.size, 2'b00};
      end
   end

   assign div_prod = 50'(div_num) * 50'(DIV5_RECIP);
   // quotient sits above the 26 fraction bits of the reciprocal
   assign div_quo  = div_prod[49:26];

   // grow by half, clamped to the maximum
   assign grow_full = {1'b0, state_i.size} + {2'b00, state_i.size[23:1]};
   assign grow_size = (grow_full > {1'b0, cfg_i.max_size}) ? cfg_i.max_size
                                                           : grow_full[23:0];

   // shrink to four fifths, clamped to the minimum
   assign shrink_size = (div_quo < cfg_i.min_size) ? cfg_i.min_size : div_quo;

   assign eligible = (state_i.ticks >= cfg_i.interval);

   // size choice for an adjust request
   always_comb begin
      next_size = state_i.size;
      if (state_i.level == LEVEL_SEVERE) begin
         next_size = grow_size;
      end else if (state_i.level == LEVEL_NONE && state_i.avg_lat < cfg_i.low_lat) begin
         next_size = shrink_size;
      end
   end

   // state update by opcode
   always_comb begin
      state_o   = state_i;
      resized_o = 1'b0;
      case (opcode_i)
         OP_SAMPLE: begin
            state_o.bytes   = state_i.bytes + 64'(pkt_bytes_i);
            state_o.packets = state_i.packets + 64'd1;
            state_o.avg_lat = (state_i.avg_lat == 20'd0) ? latency_i : div_quo[19:0];
            if (latency_i > cfg_i.severe_lat) begin
               state_o.level = LEVEL_SEVERE;
            end else if (latency_i > cfg_i.mild_lat) begin
               state_o.level = LEVEL_MILD;
            end else begin
               state_o.level = LEVEL_NONE;
            end
         end
         OP_TICK: begin
            if (state_i.ticks != TICKS_MAX) begin
               state_o.ticks = state_i.ticks + 16'd1;
            end
         end
         OP_ADJUST: begin
            if (eligible && next_size != state_i.size) begin
               state_o.size  = next_size;
               state_o.ticks = 16'd0;
               resized_o     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/adaptive_rx_buffer_sizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_rx_buffer_sizer
// Adaptive receive-buffer sizer: packet statistics, smoothed latency,
// congestion level and interval-gated buffer resizing.
// ----------------------------------------------------------------------------
// The block takes one item per clock while no result is stalled and returns
// one result per item: the item lands in an input register, and once the
// result register is free its update is computed and written into the state
// and the result register. The cycle is set by the state update path, whose
// longest leg is the shared divide-by-five multiplier followed by the clamp
// and the size compare. A stalled result holds the result register, and the
// input register still takes one more item. Configuration writes are taken at
// once (csr_ready is always high); a write of the initial size reloads the
// current size. Register indexes beyond the last register are ignored.
module adaptive_rx_buffer_sizer (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_pkt_bytes,
   input  logic [19:0] req_latency,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_buf_size,
   output logic [19:0] rsp_mean_latency,
   output logic [1:0]  rsp_congestion,
   output logic        rsp_resized,
   output logic [63:0] rsp_total_bytes,
   output logic [63:0] rsp_total_packets,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import arbs_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_opcode_ff;
   logic [15:0] in_pkt_bytes_ff;
   logic [19:0] in_latency_ff;

   cfg_type     cfg_ff, cfg_in;
   state_type   state_ff, state_in;
   state_type   upd_state;
   logic        upd_resized;

   logic        rsp_valid_ff, rsp_valid_in;
   state_type   rsp_state_ff;
   logic        rsp_resized_ff;

   logic        advance;
   logic        req_xfer;
   logic        csr_xfer;

   // result register frees when empty or taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid;

   // input register
   assign in_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_opcode_ff    <= req_opcode;
         in_pkt_bytes_ff <= req_pkt_bytes;
         in_latency_ff   <= req_latency;
      end
   end

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_MIN_SIZE:   cfg_in.min_size   = csr_wdata;
            CSR_MAX_SIZE:   cfg_in.max_size   = csr_wdata;
            CSR_INTERVAL:   cfg_in.interval   = csr_wdata[15:0];
            CSR_SEVERE_LAT: cfg_in.severe_lat = csr_wdata[19:0];
            CSR_MILD_LAT:   cfg_in.mild_lat   = csr_wdata[19:0];
            CSR_LOW_LAT:    cfg_in.low_lat    = csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_size   <= MIN_SIZE_RESET;
         cfg_ff.max_size   <= MAX_SIZE_RESET;
         cfg_ff.interval   <= INTERVAL_RESET;
         cfg_ff.severe_lat <= SEVERE_LAT_RESET;
         cfg_ff.mild_lat   <= MILD_LAT_RESET;
         cfg_ff.low_lat    <= LOW_LAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // item update
   arbs_update u_update (
      .cfg_i       (cfg_ff),
      .state_i     (state_ff),
      .opcode_i    (in_opcode_ff),
      .pkt_bytes_i (in_pkt_bytes_ff),
      .latency_i   (in_latency_ff),
      .state_o     (upd_state),
      .resized_o   (upd_resized)
   );

   // state: initial size write reloads the current size
   always_comb begin
      state_in = state_ff;
      if (in_valid_ff && advance) begin
         state_in = upd_state;
      end
      if (csr_xfer && csr_index == CSR_INIT_SIZE) begin
         state_in.size = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.size    <= INIT_SIZE_RESET;
         state_ff.avg_lat <= AVG_LAT_RESET;
         state_ff.level   <= LEVEL_NONE;
         state_ff.bytes   <= 64'd0;
         state_ff.packets <= 64'd0;
         state_ff.ticks   <= 16'd0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         rsp_state_ff   <= upd_state;
         rsp_resized_ff <= upd_resized;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_buf_size      = rsp_state_ff.size;
   assign rsp_mean_latency  = rsp_state_ff.avg_lat;
   assign rsp_congestion    = rsp_state_ff.level;
   assign rsp_resized       = rsp_resized_ff;
   assign rsp_total_bytes   = rsp_state_ff.bytes;
   assign rsp_total_packets = rsp_state_ff.packets;

endmodule
`default_nettype wire

// ===== rtl/arbs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arbs_checker
// Port-level checks of the adaptive receive-buffer sizer, bound to the top.
// ----------------------------------------------------------------------------
module arbs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [23:0] rsp_buf_size,
   input  logic [19:0] rsp_mean_latency,
   input  logic [1:0]  rsp_congestion,
   input  logic        rsp_resized,
   input  logic [63:0] rsp_total_bytes,
   input  logic [63:0] rsp_total_packets
);
   import arbs_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_buf_size)
         && $stable(rsp_mean_latency) && $stable(rsp_congestion)
         && $stable(rsp_total_bytes) && $stable(rsp_total_packets)
         && $stable(rsp_resized))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // mild congestion never resizes
   a_mild_no_resize: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resized |-> rsp_congestion != LEVEL_MILD)
      else $error("resize reported at mild congestion");

   // congestion level is always a defined code
   a_level_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_congestion == LEVEL_NONE || rsp_congestion == LEVEL_MILD
         || rsp_congestion == LEVEL_SEVERE))
      else $error("congestion level out of range");

endmodule

bind adaptive_rx_buffer_sizer arbs_checker u_arbs_checker (.*);
`default_nettype wire
